/* src/ryuv_pkg.sv */
// Shared types, coefficients and codes for the RGB24 to YUV 4:2:0 converter.
// No dependencies; every other file but ryuv_ram imports this package.
`default_nettype none

package ryuv_pkg;

  // Field widths fixed by the interface
  localparam int CFG_W  = 12;
  localparam int OFF_W  = 22;
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 9;
  localparam int PROD_W = 24;

  // Unsigned Q0.16 coefficients, rounded to nearest
  localparam logic [15:0] Y_R_COEF = 16'd19595;
  localparam logic [15:0] Y_G_COEF = 16'd38470;
  localparam logic [15:0] Y_B_COEF = 16'd7471;
  localparam logic [15:0] U_R_COEF = 16'd11036;
  localparam logic [15:0] U_G_COEF = 16'd21732;
  localparam logic [15:0] V_G_COEF = 16'd27440;
  localparam logic [15:0] V_B_COEF = 16'd5328;

  // 128 in Q.16
  localparam logic [24:0] CHROMA_BIAS = 25'd8388608;

  localparam logic [7:0] LUMA_MIN   = 8'd16;
  localparam logic [7:0] LUMA_MAX   = 8'd235;
  localparam logic [7:0] CHROMA_MIN = 8'd16;
  localparam logic [7:0] CHROMA_MAX = 8'd240;

  // Result planes
  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  // Register word select (paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // One classified pixel, handed from the front end to the back end
  typedef struct packed {
    logic               store;       // even row, odd column: write pair sums
    logic               chroma;      // odd row, odd column: emit U and V
    logic [PIX_W-1:0]   luma;
    logic [OFF_W-1:0]   luma_off;
    logic [OFF_W-1:0]   chroma_off;
    logic [SUM_W-1:0]   sum_u;
    logic [SUM_W-1:0]   sum_v;
  } work_t;

  function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] lo,
                                        input logic [7:0] hi);
    logic [7:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/rgb_to_yuv420_rotating_converter_unit.sv */
// Top level of the RGB24 to YUV 4:2:0 converter: register port, front end,
// work queue and back end. Depends on ryuv_pkg, ryuv_front, ryuv_queue, ryuv_back.
//
//   channel   handshake             payload
//   pixel     pix_valid/pix_ready   blue, green, red
//   result    res_valid/res_ready   plane, offset, value, last_of_item
//   config    APB psel/penable      paddr, pwdata, prdata (width at 0, height at 4)
//
// A pixel can be accepted every cycle while the queue has room; it reaches the queue after four stages.
// The result port moves one result per cycle while res_ready is high: one for most pixels, three (Y, U, V)
// for a pixel in an odd row and odd column, so a frame averages 1.5 results a pixel.
// Reset is synchronous; the line store needs no clearing pass.
// A stalled result port fills the queue, then stops pix_ready.
`default_nettype none

module rgb_to_yuv420_rotating_converter_unit import ryuv_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire logic [PIX_W-1:0]  blue,
  input  wire logic [PIX_W-1:0]  green,
  input  wire logic [PIX_W-1:0]  red,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic      [1:0]        plane,
  output logic      [OFF_W-1:0]  offset,
  output logic      [PIX_W-1:0]  value,
  output logic                   last_of_item
);

  localparam int SLOT_W = $clog2(MAX_WIDTH / 2);
  localparam int QW     = $bits(work_t) + SLOT_W;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      default:    prdata = '0;
    endcase
  end

  logic              q_push, q_pop, q_full, q_empty;
  work_t             f_work;
  logic [SLOT_W-1:0] f_slot;
  logic [QW-1:0]     q_rdata;
  work_t             head_work;
  logic [SLOT_W-1:0] head_slot;

  ryuv_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .q_full      (q_full),
    .push        (q_push),
    .push_work   (f_work),
    .push_slot   (f_slot)
  );

  ryuv_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata({f_work, f_slot}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign head_work = q_rdata[QW-1:SLOT_W];
  assign head_slot = q_rdata[SLOT_W-1:0];

  ryuv_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .head_work   (head_work),
    .head_slot   (head_slot),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .plane       (plane),
    .offset      (offset),
    .value       (value),
    .last_of_item(last_of_item)
  );

endmodule

`default_nettype wire

/* src/ryuv_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ryuv_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/ryuv_queue.sv */
// Short FIFO between the front end and the back end.
// Depends on ryuv_pkg for the depth.
`default_nettype none

module ryuv_queue import ryuv_pkg::*; #(
  parameter int WIDTH = 80
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count past depth");

endmodule

`default_nettype wire

/* src/ryuv_front.sv */
// Front end: accepts pixels, tracks raster position, computes Y/U/V and offsets
// in a four-stage pipeline and pushes classified work into the queue.
// Depends on ryuv_pkg.
`default_nettype none

module ryuv_front import ryuv_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [CFG_W-1:0]                    frame_width,
  input  wire logic [CFG_W-1:0]                    frame_height,
  input  wire logic                                pix_valid,
  output logic                                     pix_ready,
  input  wire logic [PIX_W-1:0]                    blue,
  input  wire logic [PIX_W-1:0]                    green,
  input  wire logic [PIX_W-1:0]                    red,
  input  wire logic                                q_full,
  output logic                                     push,
  output work_t                                    push_work,
  output logic      [$clog2(MAX_WIDTH/2)-1:0]      push_slot
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int SLOT_W = $clog2(MAX_WIDTH / 2);
  localparam int LIN_W  = ROW_W + WW;

  // Effective geometry
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic [WW+HW-1:0]   area_prod;
  logic [WW+HW-1:0]   carea_prod;
  logic [OFF_W-1:0]   area_luma;
  logic [OFF_W-1:0]   area_chroma;

  assign w_eff = (frame_width == '0) ? WW'(1) :
                 ((32'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width));
  assign h_eff = (frame_height == '0) ? HW'(1) :
                 ((32'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height));
  assign area_prod  = w_eff * h_eff;
  assign carea_prod = (w_eff >> 1) * (h_eff >> 1);

  always_ff @(posedge clk) begin
    area_luma   <= OFF_W'(area_prod);
    area_chroma <= OFF_W'(carea_prod);
  end

  // Raster position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [WW:0]      col_inc;
  logic [HW:0]      row_inc;
  logic             advance;
  logic             accept;
  logic             s4_valid;

  assign advance   = !s4_valid || !q_full;
  assign pix_ready = advance;
  assign accept    = pix_valid && advance;
  assign push      = s4_valid && !q_full;

  assign col_inc = (WW + 1)'(col) + 1'b1;
  assign row_inc = (HW + 1)'(row) + 1'b1;

  always_comb begin
    col_next = col;
    row_next = row;
    if (col_inc >= (WW + 1)'(w_eff)) begin
      col_next = '0;
      row_next = (row_inc >= (HW + 1)'(h_eff)) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Stage 1: captured pixel and position
  logic             s1_valid;
  logic [PIX_W-1:0] s1_blue, s1_green, s1_red;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;

  // Stage 2: products
  logic              s2_valid;
  logic [PROD_W-1:0] s2_yr, s2_yg, s2_yb, s2_ur, s2_ug, s2_vg, s2_vb;
  logic [6:0]        s2_bh, s2_rh;
  logic [LIN_W-1:0]  s2_lin;
  logic [LIN_W-1:0]  s2_cidx;
  logic [COL_W-1:0]  s2_col;
  logic              s2_odd_row;

  // Stage 3: samples and offsets
  logic              s3_valid;
  logic [PIX_W-1:0]  s3_luma, s3_u, s3_v;
  logic [OFF_W-1:0]  s3_luma_off, s3_chroma_off;
  logic              s3_odd_col, s3_odd_row;
  logic [SLOT_W-1:0] s3_slot;

  // Stage 4: queue entry
  logic [PIX_W-1:0]  held_u, held_v;

  logic [25:0]       y_sum;
  logic [24:0]       u_acc;
  logic [24:0]       v_acc;
  logic [OFF_W-1:0]  lin_sum;
  logic [OFF_W-1:0]  cidx_sum;

  assign y_sum = 26'(s2_yr) + 26'(s2_yg) + 26'(s2_yb);
  assign u_acc = CHROMA_BIAS + {2'b00, s2_bh, 16'h0000} - 25'(s2_ur) - 25'(s2_ug);
  assign v_acc = CHROMA_BIAS + {2'b00, s2_rh, 16'h0000} - 25'(s2_vg) - 25'(s2_vb);
  assign lin_sum  = OFF_W'(s2_lin) + OFF_W'(s2_col);
  assign cidx_sum = OFF_W'(s2_cidx) + OFF_W'(s2_col >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      held_u   <= '0;
      held_v   <= '0;
    end else if (advance) begin
      s1_valid <= pix_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      // hold the even column's chroma for its odd partner
      if (s3_valid && !s3_odd_col) begin
        held_u <= s3_u;
        held_v <= s3_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_blue  <= blue;
      s1_green <= green;
      s1_red   <= red;
      s1_col   <= col;
      s1_row   <= row;

      s2_yr      <= s1_red   * Y_R_COEF;
      s2_yg      <= s1_green * Y_G_COEF;
      s2_yb      <= s1_blue  * Y_B_COEF;
      s2_ur      <= s1_red   * U_R_COEF;
      s2_ug      <= s1_green * U_G_COEF;
      s2_vg      <= s1_green * V_G_COEF;
      s2_vb      <= s1_blue  * V_B_COEF;
      s2_bh      <= s1_blue[7:1];
      s2_rh      <= s1_red[7:1];
      s2_lin     <= s1_row * w_eff;
      s2_cidx    <= (s1_row >> 1) * (w_eff >> 1);
      s2_col     <= s1_col;
      s2_odd_row <= s1_row[0];

      s3_luma       <= clamp8(y_sum[23:16], LUMA_MIN, LUMA_MAX);
      s3_u          <= u_acc[23:16];
      s3_v          <= v_acc[23:16];
      s3_luma_off   <= area_luma - OFF_W'(1) - lin_sum;
      s3_chroma_off <= area_chroma - OFF_W'(1) - cidx_sum;
      s3_odd_col    <= s2_col[0];
      s3_odd_row    <= s2_odd_row;
      s3_slot       <= SLOT_W'(s2_col >> 1);

      push_work.store      <= s3_odd_col && !s3_odd_row;
      push_work.chroma     <= s3_odd_col && s3_odd_row;
      push_work.luma       <= s3_luma;
      push_work.luma_off   <= s3_luma_off;
      push_work.chroma_off <= s3_chroma_off;
      push_work.sum_u      <= {1'b0, held_u} + {1'b0, s3_u};
      push_work.sum_v      <= {1'b0, held_v} + {1'b0, s3_v};
      push_slot            <= s3_slot;
    end
  end

endmodule

`default_nettype wire

/* src/ryuv_back.sv */
// Back end: pops classified work, keeps the even-row pair sums in the line
// store, averages 2x2 chroma and drives the result register.
// Depends on ryuv_pkg and ryuv_ram.
`default_nettype none

module ryuv_back import ryuv_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_empty,
  output logic                                pop,
  input  wire work_t                          head_work,
  input  wire logic [$clog2(MAX_WIDTH/2)-1:0] head_slot,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic      [1:0]                     plane,
  output logic      [OFF_W-1:0]               offset,
  output logic      [PIX_W-1:0]               value,
  output logic                                last_of_item
);

  localparam int DEPTH  = MAX_WIDTH / 2;

  typedef enum logic [2:0] {
    ST_LUMA = 3'b001,
    ST_U    = 3'b010,
    ST_V    = 3'b100
  } emit_state_t;

  emit_state_t         state;
  work_t               cur;
  logic                cur_valid;
  logic                out_load;
  logic                emit;
  logic                finish;
  logic [2*SUM_W-1:0]  pair_rd;
  logic [SUM_W:0]      avg_u_sum, avg_v_sum;
  logic [PIX_W-1:0]    avg_u, avg_v;

  assign out_load = !res_valid || res_ready;
  assign emit     = cur_valid && out_load;
  assign finish   = emit && ((state == ST_V) || (state == ST_LUMA && !cur.chroma));
  assign pop      = !q_empty && (!cur_valid || finish);

  // Line store: write on an even-row, odd-column pop, read on an odd-row, odd-column pop
  ryuv_ram #(
    .WIDTH(2 * SUM_W),
    .DEPTH(DEPTH)
  ) u_pair_ram (
    .clk  (clk),
    .we   (pop && head_work.store),
    .waddr(head_slot),
    .wdata({head_work.sum_u, head_work.sum_v}),
    .re   (pop && head_work.chroma),
    .raddr(head_slot),
    .rdata(pair_rd)
  );

  assign avg_u_sum = (SUM_W + 1)'(pair_rd[2*SUM_W-1:SUM_W]) + (SUM_W + 1)'(cur.sum_u);
  assign avg_v_sum = (SUM_W + 1)'(pair_rd[SUM_W-1:0]) + (SUM_W + 1)'(cur.sum_v);
  assign avg_u = clamp8(avg_u_sum[SUM_W:2], CHROMA_MIN, CHROMA_MAX);
  assign avg_v = clamp8(avg_v_sum[SUM_W:2], CHROMA_MIN, CHROMA_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      state     <= ST_LUMA;
    end else if (pop) begin
      cur_valid <= 1'b1;
      state     <= ST_LUMA;
    end else if (finish) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      unique case (state)
        ST_LUMA: state <= ST_U;
        ST_U:    state <= ST_V;
        ST_V:    state <= ST_LUMA;
        default: state <= ST_LUMA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head_work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (state)
        ST_LUMA: begin
          plane        <= PLANE_Y;
          offset       <= cur.luma_off;
          value        <= cur.luma;
          last_of_item <= !cur.chroma;
        end
        ST_U: begin
          plane        <= PLANE_U;
          offset       <= cur.chroma_off;
          value        <= avg_u;
          last_of_item <= 1'b0;
        end
        ST_V: begin
          plane        <= PLANE_V;
          offset       <= cur.chroma_off;
          value        <= avg_v;
          last_of_item <= 1'b1;
        end
        default: begin
          plane        <= PLANE_Y;
          offset       <= cur.luma_off;
          value        <= cur.luma;
          last_of_item <= 1'b1;
        end
      endcase
    end
  end

  a_u_follows_luma: assert property (@(posedge clk) disable iff (rst)
      (res_valid && res_ready && plane == PLANE_Y && !last_of_item)
      |=> (res_valid && plane == PLANE_U))
    else $error("luma without last not followed by U");
  a_v_follows_u: assert property (@(posedge clk) disable iff (rst)
      (res_valid && res_ready && plane == PLANE_U) |=> (res_valid && plane == PLANE_V))
    else $error("U not followed by V");
  a_v_is_last: assert property (@(posedge clk) disable iff (rst)
      (res_valid && plane == PLANE_V) |-> last_of_item)
    else $error("V result not marked last");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking bench for rgb_to_yuv420_rotating_converter_unit: streams pixel
// requests under random idling and APB geometry changes, predicts every Y/U/V sample.
// Depends on ryuv_pkg and the converter RTL.
module tb import ryuv_pkg::*; ();

  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  localparam int PHASES = 10;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 200000;

  // Q0.16 conversion weights
  localparam int YR = 19595;
  localparam int YG = 38470;
  localparam int YB = 7471;
  localparam int UR = 11036;
  localparam int UG = 21732;
  localparam int VG = 27440;
  localparam int VB = 5328;
  localparam int BIAS_Q16 = 8388608;

  localparam logic [7:0] Y_LO = 8'd16;
  localparam logic [7:0] Y_HI = 8'd235;
  localparam logic [7:0] C_LO = 8'd16;
  localparam logic [7:0] C_HI = 8'd240;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [1:0]       plane;
    logic [OFF_W-1:0] offset;
    logic [PIX_W-1:0] value;
    logic             last;
  } yuv_sample_t;

  typedef struct packed {
    logic [CFG_W-1:0] col;
    logic [CFG_W-1:0] row;
  } raster_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic pix_valid = 1'b0;
  logic pix_ready;
  logic [PIX_W-1:0] blue = '0;
  logic [PIX_W-1:0] green = '0;
  logic [PIX_W-1:0] red = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [1:0] plane;
  logic [OFF_W-1:0] offset;
  logic [PIX_W-1:0] value;
  logic last_of_item;

  // Converter shadow: geometry, line store of even-row pair sums, raster position
  logic [CFG_W-1:0] frame_w = 12'd640;
  logic [CFG_W-1:0] frame_h = 12'd480;
  logic [17:0] pair_store [0:1023];
  logic [15:0] held_uv = '0;
  raster_t pix_pos = '0;
  raster_t gen_pos = '0;

  rgb_t pending_px [$];
  yuv_sample_t expected_samples [$];
  rgb_t head_px;
  rgb_t taken_px;

  int fails = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  logic calm = 1'b0;
  logic pressure_armed = 1'b0;
  logic pressure_done = 1'b0;

  rgb_to_yuv420_rotating_converter_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pix_valid(pix_valid), .pix_ready(pix_ready),
    .blue(blue), .green(green), .red(red),
    .res_valid(res_valid), .res_ready(res_ready),
    .plane(plane), .offset(offset), .value(value), .last_of_item(last_of_item)
  );

  always #4 clk = ~clk;

  function automatic int clip_dim(input logic [CFG_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [7:0] bound_sample(input logic [7:0] v, input logic [7:0] lo,
                                              input logic [7:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic raster_t next_raster(input raster_t p);
    int w;
    int h;
    w = clip_dim(frame_w, MAX_W);
    h = clip_dim(frame_h, MAX_H);
    if (p.col + 1 >= w) begin
      p.col = '0;
      p.row = (p.row + 1 >= h) ? '0 : p.row + 1'b1;
    end else begin
      p.col = p.col + 1'b1;
    end
    return p;
  endfunction

  // Luma for every pixel; U and V for the odd-row, odd-column corner of each block.
  function automatic void convert_pixel(input rgb_t px);
    int w;
    int h;
    int r;
    int g;
    int b;
    logic [31:0] acc;
    logic [31:0] off;
    logic [7:0] pu;
    logic [7:0] pv;
    logic [8:0] su;
    logic [8:0] sv;
    logic [9:0] tu;
    logic [9:0] tv;
    logic [17:0] pair;
    logic corner;
    yuv_sample_t smp;
    w = clip_dim(frame_w, MAX_W);
    h = clip_dim(frame_h, MAX_H);
    r = px.red;
    g = px.green;
    b = px.blue;
    corner = pix_pos.col[0] & pix_pos.row[0];

    acc = YR * r + YG * g + YB * b;
    off = w * h - 1 - (pix_pos.row * w + pix_pos.col);
    smp.plane = PLANE_Y;
    smp.offset = off[OFF_W-1:0];
    smp.value = bound_sample(acc[23:16], Y_LO, Y_HI);
    smp.last = ~corner;
    expected_samples.push_back(smp);

    acc = BIAS_Q16 + ((b >> 1) << 16) - UR * r - UG * g;
    pu = acc[23:16];
    acc = BIAS_Q16 + ((r >> 1) << 16) - VG * g - VB * b;
    pv = acc[23:16];

    if (!pix_pos.col[0]) begin
      held_uv = {pu, pv};
    end else begin
      su = {1'b0, held_uv[15:8]} + {1'b0, pu};
      sv = {1'b0, held_uv[7:0]} + {1'b0, pv};
      if (!pix_pos.row[0]) begin
        pair_store[pix_pos.col[10:1]] = {su, sv};
      end else begin
        pair = pair_store[pix_pos.col[10:1]];
        tu = {1'b0, pair[17:9]} + {1'b0, su};
        tv = {1'b0, pair[8:0]} + {1'b0, sv};
        off = (w / 2) * (h / 2) - 1 - ((pix_pos.row >> 1) * (w / 2) + (pix_pos.col >> 1));
        smp.offset = off[OFF_W-1:0];
        smp.plane = PLANE_U;
        smp.value = bound_sample(tu[9:2], C_LO, C_HI);
        smp.last = 1'b0;
        expected_samples.push_back(smp);
        smp.plane = PLANE_V;
        smp.value = bound_sample(tv[9:2], C_LO, C_HI);
        smp.last = 1'b1;
        expected_samples.push_back(smp);
      end
    end
    pix_pos = next_raster(pix_pos);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Geometry per random phase, width in the high half; both extremes of each register
  function automatic logic [2*CFG_W-1:0] phase_geometry(input int ph);
    case (ph)
      0: return {12'd3, 12'd3};
      1: return {12'd0, 12'hFFF};
      2: return {12'hFFF, 12'd0};
      3: return {12'd6, 12'd5};
      4: return {12'd16, 12'd8};
      5: return {12'd2048, 12'd2048};
      6: return {12'd4, 12'd2};
      7: return {12'd5, 12'd3};
      8: return {12'd2, 12'hFFF};
      default: return {12'd4, 12'd4};
    endcase
  endfunction

  task automatic queue_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    rgb_t px;
    px.blue = b;
    px.green = g;
    px.red = r;
    pending_px.push_back(px);
    gen_pos = next_raster(gen_pos);
  endtask

  task automatic queue_random_pixel();
    queue_pixel(pick_byte(), pick_byte(), pick_byte());
  endtask

  task automatic wait_idle();
    while (pending_px.size() != 0 || expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [CFG_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{(32-CFG_W){1'b0}}, data};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_HEIGHT) frame_h = data;
    else frame_w = data;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    // Widening inside an odd row would read pair sums no even row stored: finish the row.
    if (gen_pos.row[0] && clip_dim(w, MAX_W) > clip_dim(frame_w, MAX_W)) begin
      while (gen_pos.row[0]) queue_random_pixel();
      wait_idle();
    end
    write_reg({REG_WIDTH, 2'b00}, w);
    write_reg({REG_HEIGHT, 2'b00}, h);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Pixel driver: pop the accepted request, then offer the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      send_idle = 0;
    end else begin
      if (pix_valid && pix_ready) begin
        taken_px = pending_px.pop_front();
        convert_pixel(taken_px);
      end
      if (!pix_valid || pix_ready) begin
        if (send_idle == 0 && !calm && pending_px.size() != 0 && $urandom_range(0, 11) == 0)
          send_idle = $urandom_range(1, 16);
        if (send_idle != 0) begin
          send_idle--;
          pix_valid <= 1'b0;
        end else if (pending_px.size() != 0) begin
          head_px = pending_px[0];
          pix_valid <= 1'b1;
          blue <= head_px.blue;
          green <= head_px.green;
          red <= head_px.red;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest expected sample, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: plane %0d offset %0d value %0d", plane, offset, value);
          fails++;
        end else begin
          compare_field("plane", expected_samples[0].plane, plane);
          compare_field("offset", expected_samples[0].offset, offset);
          compare_field("value", expected_samples[0].value, value);
          compare_field("last_of_item", expected_samples[0].last, last_of_item);
          expected_samples.delete(0);
        end
      end
      // Hold off long enough for the converter to back up into its pixel input.
      if (pressure_armed && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (recv_idle != 0) begin
        recv_idle--;
        res_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_idle = $urandom_range(0, 15);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n;
    int k;
    int ph;
    logic [2*CFG_W-1:0] geo;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: luma clamps at black and white, primaries, first pair stored
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd255);
    queue_pixel(8'd0, 8'd255, 8'd0);
    wait_idle();

    // Shrink to 2x2 mid-row: the pending column lies past the width and wraps,
    // and its luma offset goes negative.
    set_geometry(12'd2, 12'd2);
    @(negedge clk);
    queue_pixel(8'd128, 8'd64, 8'd32);
    queue_pixel(8'd1, 8'd254, 8'd127);
    queue_pixel(8'd170, 8'd85, 8'd200);
    // Uniform blocks drive U and V to both clamps.
    for (k = 0; k < 4; k++) queue_pixel(8'd255, 8'd0, 8'd0);
    for (k = 0; k < 4; k++) queue_pixel(8'd0, 8'd0, 8'd255);
    for (k = 0; k < 4; k++) queue_pixel(8'd255, 8'd255, 8'd0);
    for (k = 0; k < 4; k++) queue_pixel(8'd0, 8'd255, 8'd255);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) calm = 1'b1;
      geo = phase_geometry(ph);
      set_geometry(geo[2*CFG_W-1:CFG_W], geo[CFG_W-1:0]);
      @(negedge clk);
      if (ph == 3) pressure_armed = 1'b1;
      n = $urandom_range(24, 40);
      repeat (n) queue_random_pixel();
      wait_idle();
    end

    if (fails == 0 && expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
